/* src/ssw_pkg.sv */
`timescale 1ns / 1ps

package ssw_pkg;

	localparam int MAX_SERVOS = 15;

	localparam logic [7:0] HDR_SYNC      = 8'hFF;
	localparam logic [7:0] HDR_BROADCAST = 8'hFE;
	localparam logic [7:0] OP_SYNC_WRITE = 8'h83;
	localparam logic [7:0] START_ADDR    = 8'd41;
	localparam logic [7:0] DATA_LEN      = 8'd7;
	localparam logic [11:0] POS_MAX      = 12'd4095;

	// Configuration register indexes.
	localparam logic CFG_ACCELERATION = 1'b0;
	localparam logic CFG_REC_COUNT    = 1'b1;

	// One classified servo record handed from the front to the back.
	typedef struct packed {
		logic [7:0]  bus_id;
		logic [11:0] position;
		logic [15:0] speed;
		logic        first;
		logic        last;
	} ssw_job_t;

endpackage

/* src/ssw_if.sv */
`timescale 1ns / 1ps

interface ssw_rec_if;
	logic               valid;
	logic               ready;
	logic [7:0]         bus_id;
	logic signed [15:0] target_angle;
	logic signed [16:0] scale;
	logic [11:0]        offset;
	logic [15:0]        speed;

	modport source (output valid, bus_id, target_angle, scale, offset, speed, input ready);
	modport sink (input valid, bus_id, target_angle, scale, offset, speed, output ready);
endinterface

interface ssw_tx_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       frame_last;

	modport source (output valid, tx_byte, frame_last, input ready);
	modport sink (input valid, tx_byte, frame_last, output ready);
endinterface

/* src/ssw_front.sv */
`timescale 1ns / 1ps

module ssw_front import ssw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [3:0] count_eff,
	ssw_rec_if.sink    rec,
	output logic       push_valid,
	input  logic       push_ready,
	output ssw_job_t   push_job
);

	logic               valid_s1;
	logic signed [32:0] prod_s1;
	logic [11:0]        offset_s1;
	logic [7:0]         id_s1;
	logic [15:0]        speed_s1;
	logic               first_s1;
	logic               last_s1;
	logic [3:0]         record_index_q;

	logic               accept;
	logic [4:0]         next_index;
	logic               is_last;
	logic signed [33:0] v;
	logic [11:0]        position;

	assign rec.ready  = !valid_s1 || push_ready;
	assign accept     = rec.valid && rec.ready;
	assign next_index = {1'b0, record_index_q} + 5'd1;
	assign is_last    = next_index >= {1'b0, count_eff};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			record_index_q <= '0;
		end else begin
			if (accept) begin
				valid_s1       <= 1'b1;
				record_index_q <= is_last ? 4'd0 : next_index[3:0];
			end else if (push_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_s1   <= 33'(rec.scale) * 33'(rec.target_angle);
			offset_s1 <= rec.offset;
			id_s1     <= rec.bus_id;
			speed_s1  <= rec.speed;
			first_s1  <= (record_index_q == 4'd0);
			last_s1   <= is_last;
		end
	end

	// Position in Q.12: negative clamps to zero, anything past 12 integer bits to full scale.
	assign v = 34'(prod_s1) + $signed({10'd0, offset_s1, 12'd0});

	always_comb begin
		if (v[33])
			position = '0;
		else if (v[32:24] != '0)
			position = POS_MAX;
		else
			position = v[23:12];
	end

	assign push_valid         = valid_s1;
	assign push_job.bus_id    = id_s1;
	assign push_job.position  = position;
	assign push_job.speed     = speed_s1;
	assign push_job.first     = first_s1;
	assign push_job.last      = last_s1;

endmodule

/* src/ssw_queue.sv */
`timescale 1ns / 1ps

module ssw_queue import ssw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  ssw_job_t push_job,
	output logic     head_valid,
	input  logic     pop,
	output ssw_job_t head_job
);

	ssw_job_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign head_valid = (fill_q != 2'd0);
	assign head_job   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= !wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop)
				fill_q <= fill_q + 2'd1;
			else if (!do_push && do_pop)
				fill_q <= fill_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_job;
	end

endmodule

/* src/ssw_back.sv */
`timescale 1ns / 1ps

module ssw_back import ssw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] acceleration,
	input  logic [3:0] count_eff,
	input  logic       head_valid,
	input  ssw_job_t   head_job,
	output logic       pop,
	ssw_tx_if.source   tx
);

	typedef enum logic [3:0] {
		SLOT_SYNC0, SLOT_SYNC1, SLOT_BCAST, SLOT_LEN, SLOT_OP, SLOT_ADDR, SLOT_DLEN,
		SLOT_ID, SLOT_ACC, SLOT_POS_LO, SLOT_POS_HI, SLOT_ZERO0, SLOT_ZERO1,
		SLOT_SPD_LO, SLOT_SPD_HI, SLOT_CHK
	} slot_t;

	slot_t      slot_q;
	logic       active_q;
	logic [7:0] sum_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	slot_t      slot;
	logic       step;
	logic [7:0] byte_val;
	logic       done;

	// A record that opens a frame starts at the header, any other at its id.
	assign slot = active_q ? slot_q : (head_job.first ? SLOT_SYNC0 : SLOT_ID);
	assign step = head_valid && (!out_valid_q || tx.ready);
	assign done = (slot == SLOT_CHK) || (slot == SLOT_SPD_HI && !head_job.last);
	assign pop  = step && done;

	always_comb begin
		case (slot)
			SLOT_SYNC0, SLOT_SYNC1: byte_val = HDR_SYNC;
			SLOT_BCAST:             byte_val = HDR_BROADCAST;
			SLOT_LEN:               byte_val = {1'b0, count_eff, 3'b000} + 8'd4;
			SLOT_OP:                byte_val = OP_SYNC_WRITE;
			SLOT_ADDR:              byte_val = START_ADDR;
			SLOT_DLEN:              byte_val = DATA_LEN;
			SLOT_ID:                byte_val = head_job.bus_id;
			SLOT_ACC:               byte_val = acceleration;
			SLOT_POS_LO:            byte_val = head_job.position[7:0];
			SLOT_POS_HI:            byte_val = {4'd0, head_job.position[11:8]};
			SLOT_SPD_LO:            byte_val = head_job.speed[7:0];
			SLOT_SPD_HI:            byte_val = head_job.speed[15:8];
			SLOT_CHK:               byte_val = ~sum_q;
			default:                byte_val = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= SLOT_SYNC0;
			active_q    <= 1'b0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (step) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= byte_val;
				out_last_q  <= (slot == SLOT_CHK);
				if (done) begin
					active_q <= 1'b0;
				end else begin
					active_q <= 1'b1;
					slot_q   <= slot_t'(slot + 4'd1);
				end
				// The checksum covers every byte from the broadcast id onward.
				if (slot == SLOT_SYNC0 || slot == SLOT_SYNC1 || slot == SLOT_CHK)
					sum_q <= '0;
				else
					sum_q <= sum_q + byte_val;
			end else if (tx.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign tx.valid      = out_valid_q;
	assign tx.tx_byte    = out_byte_q;
	assign tx.frame_last = out_last_q;

endmodule

/* src/servo_sync_write_framer.sv */
`timescale 1ns / 1ps
// Channel | Dir | Payload
// rec     | in  | bus_id, target_angle, scale, offset, speed (one servo record)
// tx      | out | tx_byte, frame_last (one frame byte per beat)
// cfg     | in  | cfg_we, cfg_index, cfg_data (0 acceleration, 1 record count)
// The back end sends one byte per cycle unless tx stalls or the queue is empty.
// A record is 8 to 16 bytes: 8, plus 7 if it opens a frame and 1 if it closes one.
// The front end multiplies in one stage and fills a two-entry queue, so it takes new
// records while the back end is still sending, and stalls only when the queue is full
// and its stage still holds a record.
// A stall on tx holds the output register and backs up into the queue.
// Reset clears the frame position, the running checksum and sets the record count to 1.

module servo_sync_write_framer import ssw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	ssw_rec_if.sink    rec,
	ssw_tx_if.source   tx
);

	logic [7:0] acceleration_q;
	logic [3:0] rec_count_q;
	logic [3:0] count_eff;
	logic       push_valid;
	logic       push_ready;
	ssw_job_t   push_job;
	logic       head_valid;
	logic       pop;
	ssw_job_t   head_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acceleration_q <= '0;
			rec_count_q    <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ACCELERATION: acceleration_q <= cfg_data;
				CFG_REC_COUNT:    rec_count_q    <= cfg_data[3:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		if (rec_count_q == 4'd0)
			count_eff = 4'd1;
		else if (32'(rec_count_q) > MAX_SERVOS)
			count_eff = 4'(MAX_SERVOS);
		else
			count_eff = rec_count_q;
	end

	ssw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.count_eff  (count_eff),
		.rec        (rec),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	ssw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.head_valid (head_valid),
		.pop        (pop),
		.head_job   (head_job)
	);

	ssw_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.acceleration (acceleration_q),
		.count_eff    (count_eff),
		.head_valid   (head_valid),
		.head_job     (head_job),
		.pop          (pop),
		.tx           (tx)
	);

endmodule
